// File: hw/rtl/ilir_pkg.sv
package ilir_pkg;

    // command codes carried by an input word
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // status codes carried by a result word
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // shift order broadcast to every cell
    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2
    } t_shift;

    localparam int unsigned DataW = 32;

    typedef logic signed [DataW-1:0] t_data;

    // control group sent from the top level to the cell row
    typedef struct packed {
        t_shift op;
        t_data  value;
    } t_cell_ctrl;

endpackage

// File: hw/rtl/ilir_cell.sv
module ilir_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned PW  = 5
) (
    input  logic                i_clk,
    input  ilir_pkg::t_cell_ctrl i_ctrl,
    input  logic [PW-1:0]       i_pos,
    input  ilir_pkg::t_data     i_left,
    input  ilir_pkg::t_data     i_right,
    output ilir_pkg::t_data     o_data
);
    import ilir_pkg::*;

    localparam logic [PW-1:0] MyIdx = PW'(IDX);

    t_data r_data;
    t_data n_data;
    logic  w_at_pos;
    logic  w_above;

    // where this cell sits relative to the target position
    assign w_at_pos = (MyIdx == i_pos);
    assign w_above  = (MyIdx > i_pos);

    // next entry: hold, take the lower neighbor, the new value, or the upper neighbor
    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            SH_INSERT: begin
                if (w_above) begin
                    n_data = i_left;
                end else if (w_at_pos) begin
                    n_data = i_ctrl.value;
                end
            end
            SH_REMOVE: begin
                if (w_above || w_at_pos) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: hw/rtl/indexed_list_insert_remove_unit.sv
// a result word is registered and appears in the cycle after its input word is accepted
// throughput: one word per cycle while result words are taken; the cell row shifts all entries together
// input ready stays high while the result register is empty or being taken
// reset clears the entry count and the result valid flag
// entries are not cleared by reset and hold their bits until shifted or written
module indexed_list_insert_remove_unit #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned PW    = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_cmd,
    input  logic [PW-1:0]        i_position,
    input  logic signed [31:0]   i_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic signed [31:0]   o_read_value,
    output logic [PW-1:0]        o_count
);
    import ilir_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] Full = PW'(DEPTH);

    t_data         w_cell_data [DEPTH];
    t_data         w_left      [DEPTH];
    t_data         w_right     [DEPTH];
    t_cell_ctrl    w_ctrl;
    t_cmd          w_cmd;
    logic          w_accept;
    t_status       w_status;
    t_data         w_rd;
    logic [PW-1:0] w_count_next;

    logic [PW-1:0] r_count;
    logic [PW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    t_status       r_status;
    t_data         r_read_value;
    logic [PW-1:0] r_out_count;

    assign w_cmd      = t_cmd'(i_cmd);
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // command decode: status, read data, new count, shift order
    always_comb begin
        w_status     = ST_DONE;
        w_rd         = '0;
        w_count_next = r_count;
        w_ctrl.op    = SH_HOLD;
        w_ctrl.value = i_value;
        case (w_cmd)
            CMD_INSERT: begin
                if (i_position > r_count) begin
                    w_status = ST_RANGE;
                end else if (r_count == Full) begin
                    w_status = ST_FULL;
                end else begin
                    w_count_next = r_count + 1'b1;
                    w_ctrl.op    = SH_INSERT;
                end
            end
            CMD_REMOVE: begin
                if (i_position >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_count_next = r_count - 1'b1;
                    w_ctrl.op    = SH_REMOVE;
                end
            end
            CMD_READ: begin
                if (i_position >= r_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rd = w_cell_data[i_position[AW-1:0]];
                end
            end
            default: w_count_next = '0;
        endcase
        if (!w_accept) begin
            w_ctrl.op = SH_HOLD;
        end
    end

    // neighbor links of the cell row
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_left[i]  = (i == 0) ? '0 : w_cell_data[(i == 0) ? 0 : i - 1];
            w_right[i] = (i == DEPTH - 1) ? '0 : w_cell_data[(i == DEPTH - 1) ? i : i + 1];
        end
    end

    // cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ilir_cell #(
            .IDX (g),
            .PW  (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_pos   (i_position),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_data  (w_cell_data[g])
        );
    end

    // count and result valid next values
    always_comb begin
        n_count     = w_accept ? w_count_next : r_count;
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= w_status;
            r_read_value <= w_rd;
            r_out_count  <= w_count_next;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;
    assign o_count      = r_out_count;

endmodule

// File: hw/rtl/ilir_checker.sv
module ilir_checker #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned PW    = $clog2(DEPTH + 1)
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [1:0]         i_cmd,
    input logic [PW-1:0]      i_position,
    input logic signed [31:0] i_value,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_read_value,
    input logic [PW-1:0]      o_count
);
    import ilir_pkg::*;

    localparam logic [PW-1:0] Full = PW'(DEPTH);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_read_value) && $stable(o_count))
        else $error("result word changed while stalled");

    // count stays within the list depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_count <= Full)
        else $error("count above depth");

    // a full status only on a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_count == Full)
        else $error("full status with room left");

    // a failed word carries zero read data
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DONE |-> o_read_value == '0)
        else $error("read data on failed word");

    // an accepted clear reports an empty list
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == CMD_CLEAR |=> o_out_valid && o_count == '0
            && o_status == ST_DONE)
        else $error("clear did not empty the list");

endmodule

bind indexed_list_insert_remove_unit ilir_checker #(
    .DEPTH (DEPTH),
    .PW    (PW)
) u_ilir_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_cmd        (i_cmd),
    .i_position   (i_position),
    .i_value      (i_value),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_read_value (o_read_value),
    .o_count      (o_count)
);

// File: tb/sv/indexed_list_insert_remove_unit_checker.sv
module indexed_list_insert_remove_unit_checker #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned PW    = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_cmd,
    input  logic [PW-1:0]        i_position,
    input  logic signed [31:0]   i_value,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [1:0]           i_status,
    input  logic signed [31:0]   i_read_value,
    input  logic [PW-1:0]        i_count,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_list_count
);
    import ilir_pkg::*;

    // one expected result word
    typedef struct packed {
        t_status       status;
        t_data         read_value;
        logic [PW-1:0] count;
    } t_list_result;

    t_list_result result_q[$];
    t_data        list_mem[DEPTH];
    int unsigned  list_len;
    int           fails;
    int           result_idx;

    // apply one command to the shadow list and return its result word
    function automatic t_list_result apply_word(t_cmd cmd, logic [PW-1:0] pos, t_data value);
        t_list_result r;
        r.status     = ST_DONE;
        r.read_value = '0;
        case (cmd)
            CMD_INSERT: begin
                if (pos > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
                    list_mem[pos] = value;
                    list_len++;
                end
            end
            CMD_REMOVE: begin
                if (pos >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            CMD_READ: begin
                if (pos >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = list_mem[pos];
                end
            end
            default: begin
                list_len = 0;
            end
        endcase
        r.count = list_len[PW-1:0];
        return r;
    endfunction

    // compare taken results first, then predict the word accepted at this edge
    always @(posedge i_clk) begin
        t_list_result exp_word;
        if (!i_rst_n) begin
            result_q.delete();
            list_len   = 0;
            fails      = 0;
            result_idx = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected result word %0d: status %0d value %0d count %0d",
                                 result_idx, i_status, i_read_value, i_count);
                    end
                    fails++;
                end else begin
                    exp_word = result_q.pop_front();
                    if (i_status !== exp_word.status || i_read_value !== exp_word.read_value ||
                        i_count !== exp_word.count) begin
                        if (fails < 10) begin
                            $display("mismatch on word %0d: status exp %0d got %0d,",
                                     result_idx, exp_word.status, i_status,
                                     " value exp %0d got %0d,",
                                     exp_word.read_value, i_read_value,
                                     " count exp %0d got %0d",
                                     exp_word.count, i_count);
                        end
                        fails++;
                    end
                end
                result_idx++;
            end
            if (i_in_valid && i_in_ready) begin
                result_q.push_back(apply_word(t_cmd'(i_cmd), i_position, i_value));
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_q.size();
        o_list_count <= list_len;
    end

endmodule

// File: tb/sv/indexed_list_insert_remove_unit_tb.sv
module indexed_list_insert_remove_unit_tb;
    import ilir_pkg::*;

    localparam int unsigned DEPTH = 16;
    localparam int unsigned PW    = $clog2(DEPTH + 1);

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_cmd;
    logic [PW-1:0]        i_position;
    logic signed [31:0]   i_value;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_status;
    logic signed [31:0]   o_read_value;
    logic [PW-1:0]        o_count;

    int fail_count;
    int pending;
    int list_count;
    int sender_idle_pct;
    int recv_stall_pct;
    bit filling;

    indexed_list_insert_remove_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_read_value(o_read_value),
        .o_count     (o_count)
    );

    indexed_list_insert_remove_unit_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (o_status),
        .i_read_value(o_read_value),
        .i_count     (o_count),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_list_count(list_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    // receiver side, stalls at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // present one word, hold it until taken, then maybe idle
    task automatic send_word(input t_cmd cmd, input logic [PW-1:0] pos, input t_data value);
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_position <= pos;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // value mix with the extremes showing up often
    function automatic t_data pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3) return 32'sh8000_0000;
        if (sel < 6) return 32'sh7fff_ffff;
        if (sel < 8) return '0;
        if (sel < 10) return -1;
        return t_data'($urandom());
    endfunction

    // random word that sweeps the list between empty and full
    task automatic send_random_word();
        int    sel;
        int    psel;
        t_cmd  cmd;
        logic [PW-1:0] pos;
        if (list_count >= DEPTH) filling = 1'b0;
        if (list_count == 0) filling = 1'b1;
        if ($urandom_range(99) < 2) filling = ~filling;
        sel = $urandom_range(99);
        if (sel < 3) begin
            cmd = CMD_CLEAR;
        end else if (sel < 23) begin
            cmd = CMD_READ;
        end else if (sel < 61) begin
            cmd = filling ? CMD_INSERT : CMD_REMOVE;
        end else if (sel < 79) begin
            cmd = filling ? CMD_REMOVE : CMD_INSERT;
        end else begin
            cmd = filling ? CMD_INSERT : CMD_REMOVE;
        end
        psel = $urandom_range(99);
        if (psel < 3) begin
            pos = PW'($urandom_range(31, DEPTH + 1));
        end else if (psel < 15) begin
            pos = PW'($urandom_range(DEPTH, 0));
        end else if (cmd == CMD_INSERT) begin
            pos = PW'($urandom_range(list_count, 0));
        end else begin
            pos = (list_count > 0) ? PW'($urandom_range(list_count - 1, 0)) : '0;
        end
        send_word(cmd, pos, pick_value());
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_cmd           <= CMD_READ;
        i_position      <= '0;
        i_value         <= '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        filling         = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, extremes, shifting, clear
        send_word(CMD_READ, PW'(0), '0);
        send_word(CMD_REMOVE, PW'(0), '0);
        send_word(CMD_INSERT, PW'(1), 32'sh1234_5678);
        send_word(CMD_INSERT, PW'(0), 32'sh8000_0000);
        send_word(CMD_INSERT, PW'(1), 32'sh7fff_ffff);
        send_word(CMD_INSERT, PW'(0), -1);
        send_word(CMD_READ, PW'(2), '0);
        send_word(CMD_READ, PW'(3), '0);
        send_word(CMD_REMOVE, PW'(1), '0);
        send_word(CMD_READ, PW'(1), '0);
        send_word(CMD_CLEAR, PW'(0), '0);
        send_word(CMD_READ, PW'(0), '0);

        // directed: fill to full, insert on a full list, then remove and read back
        for (int k = 0; k < DEPTH; k++) begin
            send_word(CMD_INSERT, (k % 2) ? PW'(k) : '0, t_data'($urandom()));
        end
        send_word(CMD_INSERT, PW'(DEPTH), 32'sh5555_aaaa);
        send_word(CMD_INSERT, PW'(0), 32'sh5555_aaaa);
        send_word(CMD_INSERT, PW'(31), 32'sh5555_aaaa);
        send_word(CMD_REMOVE, PW'(DEPTH - 1), '0);
        send_word(CMD_REMOVE, PW'(0), '0);
        send_word(CMD_READ, PW'(DEPTH - 3), '0);

        // random phases with different idling
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 88; end
                3: begin sender_idle_pct = 24; recv_stall_pct = 24; end
                default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (370) send_random_word();
        end

        // drain
        i_in_valid <= 1'b0;
        recv_stall_pct = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: indexed_list_insert_remove_unit.f
hw/rtl/ilir_pkg.sv
hw/rtl/ilir_cell.sv
hw/rtl/indexed_list_insert_remove_unit.sv
hw/rtl/ilir_checker.sv
tb/sv/indexed_list_insert_remove_unit_checker.sv
tb/sv/indexed_list_insert_remove_unit_tb.sv
